// File: rtl/mei_pkg.sv
// shared constants for the motor energy integrator
`default_nettype none

package mei_pkg;

    // default build parameters
    localparam int MOTOR_COUNT_DEF = 4;
    localparam int SPEED_BITS_DEF  = 16;

    // field widths
    localparam int TIME_W   = 32;
    localparam int PWR_W    = 40;
    localparam int ENERGY_W = 64;
    localparam int COEF_W   = 24;
    localparam int SHIFT_W  = 7;
    localparam int LIMB_W   = 32;
    localparam int POW_W    = 3;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIN_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_SHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUB_COEF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUB_SHIFT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIX_COEF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIX_SHIFT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DT    = 3'd6;

    // register reset values
    localparam logic [COEF_W-1:0]  LIN_COEF_RST  = 24'd6384;
    localparam logic [SHIFT_W-1:0] LIN_SHIFT_RST = 7'd8;
    localparam logic [COEF_W-1:0]  CUB_COEF_RST  = 24'd5277656;
    localparam logic [SHIFT_W-1:0] CUB_SHIFT_RST = 7'd44;
    localparam logic [COEF_W-1:0]  SIX_COEF_RST  = 24'd5957587;
    localparam logic [SHIFT_W-1:0] SIX_SHIFT_RST = 7'd94;
    localparam logic [TIME_W-1:0]  MAX_DT_RST    = 32'd1000000;

    // exponents of the three power terms
    localparam logic [POW_W-1:0] POW_LIN = 3'd1;
    localparam logic [POW_W-1:0] POW_CUB = 3'd3;
    localparam logic [POW_W-1:0] POW_SIX = 3'd6;
    localparam int               POW_MAX = 6;

    localparam logic [PWR_W-1:0]    PWR_MAX    = {PWR_W{1'b1}};
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

endpackage : mei_pkg

`default_nettype wire

// File: rtl/mei_in_if.sv
// input channel: timestamp and motor speeds
`default_nettype none

interface mei_in_if #(
    parameter int MOTOR_COUNT = mei_pkg::MOTOR_COUNT_DEF,
    parameter int SPEED_BITS  = mei_pkg::SPEED_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [mei_pkg::TIME_W-1:0]        time_us;
    // motor k occupies bits [k*SPEED_BITS +: SPEED_BITS]
    logic [MOTOR_COUNT*SPEED_BITS-1:0] motor_speed;

    modport source (output valid, output time_us, output motor_speed, input ready);
    modport sink   (input valid, input time_us, input motor_speed, output ready);
endinterface : mei_in_if

`default_nettype wire

// File: rtl/mei_out_if.sv
// result channel: elapsed time, power and energy
`default_nettype none

interface mei_out_if;
    logic                         valid;
    logic                         ready;
    logic [mei_pkg::TIME_W-1:0]   elapsed_us;
    logic [mei_pkg::PWR_W-1:0]    power_sum;
    logic [mei_pkg::ENERGY_W-1:0] energy_total;

    modport source (output valid, output elapsed_us, output power_sum, output energy_total,
                    input ready);
    modport sink   (input valid, input elapsed_us, input power_sum, input energy_total,
                    output ready);
endinterface : mei_out_if

`default_nettype wire

// File: rtl/motor_energy_integrator.sv
// top level of the motor energy integrator
`default_nettype none

// Motor energy integrator. Each input transfer carries a wrapping microsecond
// timestamp and MOTOR_COUNT unsigned Q12.4 motor speeds. The first transfer
// after reset only sets the start and previous timestamps. Later transfers
// whose step dt (wrapping difference to the previous timestamp) is zero or
// larger than max_dt_us are dropped; the timestamp is stored either way.
// Otherwise each motor power (c1*w>>s1)+(c3*w^3>>s3)+(c6*w^6>>s6) is formed
// exactly, each term and the motor sum saturating at 2^40-1 (2^-16 W), and
// power*dt is added to a saturating 64-bit energy total (2^-16 uJ); one
// result transfer follows. All multiplication runs through one 32x32
// multiply-add unit: a product register of LIMBS 32-bit limbs, LIMBS =
// ceil((24 + 6*SPEED_BITS)/32), is multiplied by w one limb per cycle.
// The input is ready only while idle. A finished result sits in an output
// register, so the next item is taken while it waits; a second result
// waits for that register to drain. Configuration writes are taken at any
// time but must only be issued while the block is idle.

module motor_energy_integrator #(
    parameter int MOTOR_COUNT = mei_pkg::MOTOR_COUNT_DEF,
    parameter int SPEED_BITS  = mei_pkg::SPEED_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [mei_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mei_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // channels
    mei_in_if.sink                                i_item,
    mei_out_if.source                             o_res
);
    localparam int LW      = mei_pkg::LIMB_W;
    localparam int PW      = mei_pkg::PWR_W;
    localparam int EW      = mei_pkg::ENERGY_W;
    localparam int TW      = mei_pkg::TIME_W;
    // product register sized for coef * w^6 with no loss
    localparam int LIMBS   = (mei_pkg::COEF_W + mei_pkg::POW_MAX * SPEED_BITS + LW - 1) / LW;
    localparam int PROD_W  = LIMBS * LW;
    localparam int LIMB_IW = $clog2(LIMBS);
    localparam int MOT_IW  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,    // load coefficient of current term
        ST_MUL,     // limb-serial multiply by w
        ST_SHIFT,   // shift down and clamp the term
        ST_ADDT,    // add term into motor power
        ST_MSUM,    // add motor power into power sum
        ST_E_LO,    // low half of power * dt
        ST_E_HI,    // high byte of power * dt
        ST_E_SAT,   // combine halves, clamp step energy
        ST_ACC,     // accumulate energy
        ST_DONE     // hand result to output register
    } t_state;

    typedef enum logic [1:0] {
        TERM_LIN,
        TERM_CUB,
        TERM_SIX
    } t_term;

    // configuration registers
    logic [mei_pkg::COEF_W-1:0]  r_lin_coef, r_cub_coef, r_six_coef;
    logic [mei_pkg::SHIFT_W-1:0] r_lin_shift, r_cub_shift, r_six_shift;
    logic [TW-1:0]               r_max_dt;

    // persistent state
    logic          r_have_last;
    logic [TW-1:0] r_last_time;
    logic [TW-1:0] r_start_time;
    logic [EW-1:0] r_energy;

    // sequencer and datapath
    t_state                                  r_state;
    t_term                                   r_term_sel;
    logic [MOT_IW-1:0]                       r_motor;
    logic [LIMB_IW-1:0]                      r_limb;
    logic [mei_pkg::POW_W-1:0]               r_pow;
    logic [PROD_W-1:0]                       r_prod;
    logic [LW-1:0]                           r_carry;
    logic [MOTOR_COUNT-1:0][SPEED_BITS-1:0]  r_speed;
    logic [TW-1:0]                           r_dt;
    logic [TW-1:0]                           r_elapsed;
    logic [PW-1:0]                           r_term;
    logic [PW-1:0]                           r_mpow;
    logic [PW-1:0]                           r_psum;
    logic [2*LW-1:0]                         r_lo;
    logic [2*LW-1:0]                         r_hi;
    logic [EW-1:0]                           r_step;

    // output register
    logic          r_out_valid;
    logic [TW-1:0] r_out_elapsed;
    logic [PW-1:0] r_out_power;
    logic [EW-1:0] r_out_energy;

    // combinational helpers
    logic                        in_xfer;
    logic [TW-1:0]               in_dt;
    logic                        in_drop;
    logic [SPEED_BITS-1:0]       cur_w;
    logic [mei_pkg::COEF_W-1:0]  term_coef;
    logic [mei_pkg::SHIFT_W-1:0] term_shift;
    logic [mei_pkg::POW_W-1:0]   term_pow;
    logic [LW-1:0]               mac_a, mac_b, mac_c;
    logic [2*LW-1:0]             mac_p;
    logic [PROD_W-1:0]           shifted;
    logic [PW:0]                 term_sum;
    logic [PW:0]                 motor_sum;
    logic [EW:0]                 step_sum;
    logic [EW:0]                 acc_sum;
    logic                        out_free;
    logic                        out_load;

    assign in_xfer  = i_item.valid && i_item.ready;
    assign in_dt    = i_item.time_us - r_last_time;
    assign in_drop  = (in_dt == '0) || (in_dt > r_max_dt);
    assign cur_w    = r_speed[r_motor];
    assign out_free = !r_out_valid || o_res.ready;
    // a finished result moves into the output register this cycle
    assign out_load = (r_state == ST_DONE) && out_free;

    // per-term coefficient, shift and exponent
    always_comb begin
        case (r_term_sel)
            TERM_LIN: begin
                term_coef  = r_lin_coef;
                term_shift = r_lin_shift;
                term_pow   = mei_pkg::POW_LIN;
            end
            TERM_CUB: begin
                term_coef  = r_cub_coef;
                term_shift = r_cub_shift;
                term_pow   = mei_pkg::POW_CUB;
            end
            TERM_SIX: begin
                term_coef  = r_six_coef;
                term_shift = r_six_shift;
                term_pow   = mei_pkg::POW_SIX;
            end
            default: begin
                term_coef  = '0;
                term_shift = '0;
                term_pow   = mei_pkg::POW_LIN;
            end
        endcase
    end

    // operand select for the shared multiply-add unit
    always_comb begin
        case (r_state)
            ST_E_LO: begin
                mac_a = r_psum[LW-1:0];
                mac_b = r_dt;
                mac_c = '0;
            end
            ST_E_HI: begin
                mac_a = LW'(r_psum[PW-1:LW]);
                mac_b = r_dt;
                mac_c = '0;
            end
            default: begin
                // low limb of the product times speed, plus running carry
                mac_a = r_prod[LW-1:0];
                mac_b = LW'(cur_w);
                mac_c = r_carry;
            end
        endcase
    end

    mei_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .i_c (mac_c),
        .o_p (mac_p)
    );

    // truncating shift of the exact product, then saturating sums
    assign shifted   = r_prod >> term_shift;
    assign term_sum  = {1'b0, r_mpow} + {1'b0, r_term};
    assign motor_sum = {1'b0, r_psum} + {1'b0, r_mpow};
    assign step_sum  = {1'b0, r_hi[LW-1:0], {LW{1'b0}}} + {1'b0, r_lo};
    assign acc_sum   = {1'b0, r_energy} + {1'b0, r_step};

    assign i_item.ready     = (r_state == ST_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.elapsed_us = r_out_elapsed;
    assign o_res.power_sum  = r_out_power;
    assign o_res.energy_total = r_out_energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_coef  <= mei_pkg::LIN_COEF_RST;
            r_lin_shift <= mei_pkg::LIN_SHIFT_RST;
            r_cub_coef  <= mei_pkg::CUB_COEF_RST;
            r_cub_shift <= mei_pkg::CUB_SHIFT_RST;
            r_six_coef  <= mei_pkg::SIX_COEF_RST;
            r_six_shift <= mei_pkg::SIX_SHIFT_RST;
            r_max_dt    <= mei_pkg::MAX_DT_RST;
            r_have_last <= 1'b0;
            r_last_time <= '0;
            r_start_time <= '0;
            r_energy    <= '0;
            r_state     <= ST_IDLE;
            r_term_sel  <= TERM_LIN;
            r_motor     <= '0;
            r_limb      <= '0;
            r_pow       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes, unknown index ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mei_pkg::CFG_LIN_COEF:  r_lin_coef  <= i_cfg_data[mei_pkg::COEF_W-1:0];
                    mei_pkg::CFG_LIN_SHIFT: r_lin_shift <= i_cfg_data[mei_pkg::SHIFT_W-1:0];
                    mei_pkg::CFG_CUB_COEF:  r_cub_coef  <= i_cfg_data[mei_pkg::COEF_W-1:0];
                    mei_pkg::CFG_CUB_SHIFT: r_cub_shift <= i_cfg_data[mei_pkg::SHIFT_W-1:0];
                    mei_pkg::CFG_SIX_COEF:  r_six_coef  <= i_cfg_data[mei_pkg::COEF_W-1:0];
                    mei_pkg::CFG_SIX_SHIFT: r_six_shift <= i_cfg_data[mei_pkg::SHIFT_W-1:0];
                    mei_pkg::CFG_MAX_DT:    r_max_dt    <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end

            // output register drains unless a new result replaces it
            if (r_out_valid && o_res.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_last_time <= i_item.time_us;
                        r_speed     <= i_item.motor_speed;
                        r_dt        <= in_dt;
                        r_elapsed   <= i_item.time_us - r_start_time;
                        r_term_sel  <= TERM_LIN;
                        r_motor     <= '0;
                        r_mpow      <= '0;
                        r_psum      <= '0;
                        if (!r_have_last) begin
                            // first item only anchors the time base
                            r_have_last  <= 1'b1;
                            r_start_time <= i_item.time_us;
                        end else if (!in_drop) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    r_prod  <= PROD_W'(term_coef);
                    r_carry <= '0;
                    r_limb  <= '0;
                    r_pow   <= term_pow;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // rotate: new low limb lands on top
                    r_prod <= {mac_p[LW-1:0], r_prod[PROD_W-1:LW]};
                    if (r_limb == LIMB_IW'(LIMBS - 1)) begin
                        r_limb  <= '0;
                        r_carry <= '0;
                        r_pow   <= r_pow - 1'b1;
                        if (r_pow == mei_pkg::POW_W'(1)) begin
                            r_state <= ST_SHIFT;
                        end
                    end else begin
                        r_limb  <= r_limb + 1'b1;
                        r_carry <= mac_p[2*LW-1:LW];
                    end
                end
                ST_SHIFT: begin
                    r_term  <= (|shifted[PROD_W-1:PW]) ? mei_pkg::PWR_MAX : shifted[PW-1:0];
                    r_state <= ST_ADDT;
                end
                ST_ADDT: begin
                    r_mpow <= term_sum[PW] ? mei_pkg::PWR_MAX : term_sum[PW-1:0];
                    case (r_term_sel)
                        TERM_LIN: begin
                            r_term_sel <= TERM_CUB;
                            r_state    <= ST_LOAD;
                        end
                        TERM_CUB: begin
                            r_term_sel <= TERM_SIX;
                            r_state    <= ST_LOAD;
                        end
                        default: begin
                            r_state <= ST_MSUM;
                        end
                    endcase
                end
                ST_MSUM: begin
                    r_psum     <= motor_sum[PW] ? mei_pkg::PWR_MAX : motor_sum[PW-1:0];
                    r_mpow     <= '0;
                    r_term_sel <= TERM_LIN;
                    if (r_motor == MOT_IW'(MOTOR_COUNT - 1)) begin
                        r_state <= ST_E_LO;
                    end else begin
                        r_motor <= r_motor + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_E_LO: begin
                    r_lo    <= mac_p;
                    r_state <= ST_E_HI;
                end
                ST_E_HI: begin
                    r_hi    <= mac_p;
                    r_state <= ST_E_SAT;
                end
                ST_E_SAT: begin
                    // high part must fit 32 bits before the shift by 32
                    if ((|r_hi[2*LW-1:LW]) || step_sum[EW]) begin
                        r_step <= mei_pkg::ENERGY_MAX;
                    end else begin
                        r_step <= step_sum[EW-1:0];
                    end
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_energy <= acc_sum[EW] ? mei_pkg::ENERGY_MAX : acc_sum[EW-1:0];
                    r_state  <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out_valid   <= 1'b1;
                        r_out_elapsed <= r_elapsed;
                        r_out_power   <= r_psum;
                        r_out_energy  <= r_energy;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // energy total never falls except through reset
    a_energy_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_energy >= $past(r_energy)))
        else $error("energy total decreased");

    // a multiply pass always has an exponent left to apply
    a_pow_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_pow != '0))
        else $error("multiply pass with zero exponent");

    // energy phase only after the last motor is summed
    a_all_motors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_LO) |-> (r_motor == MOT_IW'(MOTOR_COUNT - 1)))
        else $error("energy phase before all motors summed");

    // a finished result waits while the output register is still full
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_res.ready) |=> (r_state == ST_DONE))
        else $error("result overwrote a pending output");
`endif

endmodule : motor_energy_integrator

`default_nettype wire

// File: rtl/mei_mac.sv
// shared limb multiply-accumulate unit: a * b + c
`default_nettype none

module mei_mac (
    input  wire logic [mei_pkg::LIMB_W-1:0]   i_a,
    input  wire logic [mei_pkg::LIMB_W-1:0]   i_b,
    input  wire logic [mei_pkg::LIMB_W-1:0]   i_c,
    output logic      [2*mei_pkg::LIMB_W-1:0] o_p
);
    // max result (2^32-1)^2 + 2^32-1 still fits in 64 bits
    assign o_p = ({{mei_pkg::LIMB_W{1'b0}}, i_a} * {{mei_pkg::LIMB_W{1'b0}}, i_b})
               + {{mei_pkg::LIMB_W{1'b0}}, i_c};
endmodule : mei_mac

`default_nettype wire
